>>> sv/kmps_pkg.sv
// ----------------------------------------------------------------------------
// kmps_pkg
// Shared types and constants of the k-mismatch probe search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kmps_pkg;

  localparam int MAX_PROBE  = 512;
  localparam int SYM_W      = 8;
  localparam int INDEX_W    = 9;
  localparam int LEN_W      = 10;
  localparam int LIM_W      = 6;
  localparam int CNT_W      = 7;
  localparam int CID_W      = $clog2(MAX_PROBE);
  localparam int WIDE_W     = (CID_W + 1 > LEN_W) ? CID_W + 1 : LEN_W;
  localparam int MIN_TILE   = 8;
  localparam int TILE_SH    = $clog2(MIN_TILE);

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [LEN_W-1:0] SEEN_MAX = '1;

  // hit reduction: groups ORed in the second stage
  localparam int GRP_W = (MAX_PROBE < 32) ? MAX_PROBE : 32;
  localparam int NGRP  = (MAX_PROBE + GRP_W - 1) / GRP_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int PEND_W     = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_MM    = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROBE_LEN = 1'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic               load;
    logic               step;
    logic               clear;
    logic [INDEX_W-1:0] index;
    logic [SYM_W-1:0]   symbol;
    logic [LEN_W-1:0]   len;
    logic               len_ok;
    logic               seen_ok;
    logic [LIM_W-1:0]   lim;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/kmps_cell.sv
// ----------------------------------------------------------------------------
// kmps_cell
// One probe position: holds the probe byte and the mismatch count of the
// alignment whose newest symbol faced this position.
// ----------------------------------------------------------------------------
`default_nettype none

module kmps_cell (
  input  wire                              clk,
  input  wire                              rst,
  input  kmps_pkg::cell_ctl_t              ctl,
  input  wire  [kmps_pkg::CID_W-1:0]       cid,
  input  wire  [kmps_pkg::CNT_W-1:0]       cnt_in,
  output logic [kmps_pkg::CNT_W-1:0]       cnt_out,
  output logic                             hit
);

  logic [kmps_pkg::SYM_W-1:0]  probe;
  logic [kmps_pkg::CNT_W-1:0]  cnt;
  logic [kmps_pkg::CNT_W-1:0]  sum;
  logic [kmps_pkg::WIDE_W-1:0] cid_w;
  logic [kmps_pkg::WIDE_W-1:0] len_w;
  logic [kmps_pkg::WIDE_W-1:0] idx_w;
  logic                        active;
  logic                        is_end;
  logic                        load_here;
  logic                        mm;

  always_comb begin
    cid_w     = kmps_pkg::WIDE_W'(cid);
    len_w     = kmps_pkg::WIDE_W'(ctl.len);
    idx_w     = kmps_pkg::WIDE_W'(ctl.index);
    active    = ctl.len_ok && (cid_w < len_w);
    is_end    = (cid_w + kmps_pkg::WIDE_W'(1)) == len_w;
    load_here = ctl.load && (idx_w == cid_w);
    mm        = (ctl.symbol != probe);
    if (mm && (cnt_in != kmps_pkg::CNT_MAX)) begin
      sum = cnt_in + kmps_pkg::CNT_W'(1);
    end else begin
      sum = cnt_in;
    end
    hit = ctl.step && active && is_end && ctl.seen_ok &&
          (sum <= kmps_pkg::CNT_W'(ctl.lim));
  end

  always_ff @(posedge clk) begin
    if (load_here) begin
      probe <= ctl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.clear) begin
      cnt <= '0;
    end else if (ctl.step && active) begin
      cnt <= sum;
    end
  end

  assign cnt_out = cnt;

endmodule

`default_nettype wire

>>> sv/kmps_hit_reduce.sv
// ----------------------------------------------------------------------------
// kmps_hit_reduce
// Two-stage OR tree over the cell hit flags, plus the per-read match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kmps_hit_reduce (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  [kmps_pkg::MAX_PROBE-1:0]     hit,
  input  wire                                last,
  output logic                               push,
  output logic                               found,
  output logic [kmps_pkg::PEND_W-1:0]        pend
);

  localparam int PAD_W = kmps_pkg::NGRP * kmps_pkg::GRP_W;

  logic [PAD_W-1:0]          hit_q;
  logic                      last1;
  logic [kmps_pkg::NGRP-1:0] grp_q;
  logic [kmps_pkg::NGRP-1:0] grp_next;
  logic                      last2;
  logic                      match_seen;
  logic                      any2;

  always_comb begin
    for (int g = 0; g < kmps_pkg::NGRP; g++) begin
      grp_next[g] = |hit_q[g*kmps_pkg::GRP_W +: kmps_pkg::GRP_W];
    end
    any2 = |grp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q      <= '0;
      last1      <= 1'b0;
      grp_q      <= '0;
      last2      <= 1'b0;
      match_seen <= 1'b0;
    end else begin
      hit_q <= PAD_W'(hit);
      last1 <= last;
      grp_q <= grp_next;
      last2 <= last1;
      if (last2) begin
        match_seen <= 1'b0;
      end else begin
        match_seen <= match_seen | any2;
      end
    end
  end

  assign push  = last2;
  assign found = match_seen | any2;
  assign pend  = {1'b0, last1} + {1'b0, last2};

endmodule

`default_nettype wire

>>> sv/kmps_result_fifo.sv
// ----------------------------------------------------------------------------
// kmps_result_fifo
// Small queue of result beats in front of the master port.
// ----------------------------------------------------------------------------
`default_nettype none

module kmps_result_fifo (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  input  wire                               din,
  input  wire                               pop,
  output logic                              dout,
  output logic                              valid,
  output logic [kmps_pkg::FIFO_CW-1:0]      count
);

  logic                          mem [kmps_pkg::FIFO_DEPTH];
  logic [kmps_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [kmps_pkg::FIFO_AW-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + kmps_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + kmps_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + kmps_pkg::FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - kmps_pkg::FIFO_CW'(1);
      end
    end
  end

  assign dout  = mem[rd_ptr];
  assign valid = (count != '0);

endmodule

`default_nettype wire

>>> sv/k_mismatch_probe_search_unit.sv
// ----------------------------------------------------------------------------
// k_mismatch_probe_search_unit
// Probe load and k-mismatch window search over a streamed read.
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_tready is high. Load beats (tuser = 0)
// write a probe byte; read beats (tuser = 1) advance a row of MAX_PROBE
// cells, each holding one probe byte and one saturating mismatch count
// that shifts to its neighbor. The result for a read (tlast on a read beat)
// leaves through a two-stage OR tree over the cell hit flags and a 4-entry
// result queue; s_tready drops only while queued plus in-flight results
// fill that queue. Counters clear at reset; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module k_mismatch_probe_search_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [kmps_pkg::IN_DATA_W-1:0]       s_tdata,   // index[8:0], symbol[16:9]
  input  wire                                  s_tuser,   // func
  input  wire                                  s_tlast,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [kmps_pkg::OUT_DATA_W-1:0]      m_tdata,   // found[0]
  input  wire                                  cfg_we,
  input  wire  [kmps_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire  [kmps_pkg::LEN_W-1:0]           cfg_data
);

  logic [kmps_pkg::LIM_W-1:0]   max_mm;
  logic [kmps_pkg::LEN_W-1:0]   probe_len;
  logic [kmps_pkg::LEN_W-1:0]   seen;
  logic [kmps_pkg::LEN_W-1:0]   seen_inc;
  logic [kmps_pkg::LIM_W:0]     k_plus;
  logic [kmps_pkg::LEN_W-1:0]   tile_need;
  logic [kmps_pkg::LIM_W-1:0]   eff_lim;
  logic                         accept;
  kmps_pkg::cell_ctl_t          ctl;

  logic [kmps_pkg::CNT_W-1:0]   cnt [kmps_pkg::MAX_PROBE];
  logic [kmps_pkg::MAX_PROBE-1:0] hit;

  logic                         push;
  logic                         found;
  logic [kmps_pkg::PEND_W-1:0]  pend;
  logic                         q_dout;
  logic                         q_valid;
  logic [kmps_pkg::FIFO_CW-1:0] q_count;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    k_plus    = {1'b0, max_mm} + (kmps_pkg::LIM_W + 1)'(1);
    tile_need = kmps_pkg::LEN_W'({k_plus, {kmps_pkg::TILE_SH{1'b0}}});
    if ((max_mm == '0) || (probe_len < tile_need)) begin
      eff_lim = '0;
    end else begin
      eff_lim = max_mm;
    end
    if (seen == kmps_pkg::SEEN_MAX) begin
      seen_inc = seen;
    end else begin
      seen_inc = seen + kmps_pkg::LEN_W'(1);
    end
    ctl.load    = accept && (s_tuser == kmps_pkg::FUNC_LOAD);
    ctl.step    = accept && (s_tuser == kmps_pkg::FUNC_READ);
    ctl.clear   = accept && (s_tuser == kmps_pkg::FUNC_READ) && s_tlast;
    ctl.index   = s_tdata[kmps_pkg::INDEX_W-1:0];
    ctl.symbol  = s_tdata[kmps_pkg::INDEX_W +: kmps_pkg::SYM_W];
    ctl.len     = probe_len;
    ctl.len_ok  = (probe_len != '0) &&
                  (kmps_pkg::WIDE_W'(probe_len) <= kmps_pkg::WIDE_W'(kmps_pkg::MAX_PROBE));
    ctl.seen_ok = (seen_inc >= probe_len);
    ctl.lim     = eff_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_mm    <= '0;
      probe_len <= kmps_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmps_pkg::REG_MAX_MM:    max_mm    <= cfg_data[kmps_pkg::LIM_W-1:0];
        kmps_pkg::REG_PROBE_LEN: probe_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (ctl.clear) begin
      seen <= '0;
    end else if (ctl.step) begin
      seen <= seen_inc;
    end
  end

  for (genvar j = 0; j < kmps_pkg::MAX_PROBE; j++) begin : g_cell
    kmps_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .cid     (kmps_pkg::CID_W'(j)),
      .cnt_in  ((j == 0) ? kmps_pkg::CNT_W'(0) : cnt[(j == 0) ? 0 : j - 1]),
      .cnt_out (cnt[j]),
      .hit     (hit[j])
    );
  end

  kmps_hit_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .hit   (hit),
    .last  (ctl.clear),
    .push  (push),
    .found (found),
    .pend  (pend)
  );

  kmps_result_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (found),
    .pop   (m_tvalid && m_tready),
    .dout  (q_dout),
    .valid (q_valid),
    .count (q_count)
  );

  assign s_tready = (q_count + kmps_pkg::FIFO_CW'(pend)) <
                    kmps_pkg::FIFO_CW'(kmps_pkg::FIFO_DEPTH);
  assign m_tvalid = q_valid;
  assign m_tdata  = kmps_pkg::OUT_DATA_W'(q_dout);

endmodule

`default_nettype wire

>>> verif/k_mismatch_probe_search_unit_tb.sv
// ----------------------------------------------------------------------------
// k_mismatch_probe_search_unit_tb
// Self-checking bench for the k-mismatch probe search unit.
// ----------------------------------------------------------------------------
// Loads probes, streams reads and scores every found beat against an internal
// window-count model of the unit. A short list of hand-written beats runs
// first. Random phases follow, each with a new mismatch limit and probe
// length. Most reads carry a mutated copy of the probe near the limit. Some
// probe writes land in the middle of a read. One receiver hold-off is long
// enough to back up the result queue and stall the input. A full-size probe
// at the widest limit ends the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module k_mismatch_probe_search_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_BEATS  = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int NO_TYPED    = -1;
  localparam int PRE_BEATS   = 20;

  typedef struct packed {
    logic                         func;
    logic [kmps_pkg::INDEX_W-1:0] index;
    logic [kmps_pkg::SYM_W-1:0]   symbol;
    logic                         last;
    logic                         typed;
    logic                         found;
  } dir_row_t;

  // default setup after reset: exact match, probe length 1
  localparam dir_row_t DIR_ROWS [14] = '{
    '{kmps_pkg::FUNC_LOAD, 9'd0,   8'h00, 1'b0, 1'b0, 1'b0},
    '{kmps_pkg::FUNC_LOAD, 9'd511, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'h00, 1'b1, 1'b1, 1'b1},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'hFF, 1'b1, 1'b1, 1'b0},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'hFF, 1'b0, 1'b0, 1'b0},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'h00, 1'b0, 1'b0, 1'b0},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'h55, 1'b1, 1'b1, 1'b1},
    '{kmps_pkg::FUNC_LOAD, 9'd0,   8'hAA, 1'b1, 1'b0, 1'b0},   // tlast on a load: no result
    '{kmps_pkg::FUNC_READ, 9'd0,   8'hAA, 1'b1, 1'b1, 1'b1},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'h12, 1'b0, 1'b0, 1'b0},
    '{kmps_pkg::FUNC_LOAD, 9'd0,   8'h12, 1'b0, 1'b0, 1'b0},   // probe rewritten mid-read
    '{kmps_pkg::FUNC_READ, 9'd0,   8'h12, 1'b1, 1'b1, 1'b1},
    '{kmps_pkg::FUNC_READ, 9'd0,   8'h00, 1'b1, 1'b1, 1'b0},
    '{kmps_pkg::FUNC_READ, 9'd511, 8'h12, 1'b1, 1'b1, 1'b1}
  };

  logic                              clk;
  logic                              rst       = 1'b1;
  logic                              s_tvalid  = 1'b0;
  logic                              s_tready;
  logic [kmps_pkg::IN_DATA_W-1:0]    s_tdata   = '0;   // index[8:0], symbol[16:9]
  logic                              s_tuser   = 1'b0; // func
  logic                              s_tlast   = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready  = 1'b0;
  logic [kmps_pkg::OUT_DATA_W-1:0]   m_tdata;          // found[0]
  logic                              cfg_we    = 1'b0;
  logic [kmps_pkg::REG_IDX_W-1:0]    cfg_index = '0;
  logic [kmps_pkg::LEN_W-1:0]        cfg_data  = '0;

  // search model state
  logic [kmps_pkg::SYM_W-1:0]  probe_mem [kmps_pkg::MAX_PROBE];
  logic [kmps_pkg::CNT_W-1:0]  win_cnt   [kmps_pkg::MAX_PROBE];
  logic [kmps_pkg::LEN_W-1:0]  seen_cnt;
  bit                          hit_flag;
  int                          cfg_mm;
  int                          cfg_len;

  bit found_q [$];
  bit exp_found;
  int err_cnt   = 0;
  int cyc_cnt   = 0;
  int beat_cnt  = 0;
  bit hold_req  = 1'b0;
  bit burst     = 1'b0;

  k_mismatch_probe_search_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("k_mismatch_probe_search_unit_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_limit(int len);
    if (cfg_mm == 0 || len / (cfg_mm + 1) < kmps_pkg::MIN_TILE) return 0;
    return cfg_mm;
  endfunction

  function automatic void clear_read();
    foreach (win_cnt[j]) win_cnt[j] = '0;
    seen_cnt = '0;
    hit_flag = 1'b0;
  endfunction

  task automatic track_beat(input logic f, input logic [kmps_pkg::INDEX_W-1:0] idx,
                            input logic [kmps_pkg::SYM_W-1:0] sym, input logic lst,
                            output bit got, output bit pred);
    int                         len;
    bit                         ok;
    logic [kmps_pkg::CNT_W-1:0] c;
    got  = 1'b0;
    pred = 1'b0;
    if (f == kmps_pkg::FUNC_LOAD) begin
      probe_mem[idx] = sym;
      return;
    end
    len = cfg_len;
    ok  = (len >= 1 && len <= kmps_pkg::MAX_PROBE);
    if (ok) begin
      for (int j = len - 1; j >= 1; j--) begin
        c = win_cnt[j-1];
        if (sym != probe_mem[j] && c < kmps_pkg::CNT_MAX) c++;
        win_cnt[j] = c;
      end
      win_cnt[0] = (sym != probe_mem[0]) ? 7'd1 : 7'd0;
    end
    if (seen_cnt < kmps_pkg::SEEN_MAX) seen_cnt++;
    if (ok && seen_cnt >= len && win_cnt[len-1] <= eff_limit(len)) hit_flag = 1'b1;
    if (lst) begin
      got  = 1'b1;
      pred = hit_flag;
      clear_read();
    end
  endtask

  task automatic send_beat(input logic f, input logic [kmps_pkg::INDEX_W-1:0] idx,
                           input logic [kmps_pkg::SYM_W-1:0] sym, input logic lst,
                           input int typed);
    int g;
    bit got;
    bit pred;
    g = burst ? 0 : pick_gap();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= kmps_pkg::IN_DATA_W'($urandom);
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tlast  <= lst;
    s_tdata  <= {{(kmps_pkg::IN_DATA_W - kmps_pkg::SYM_W - kmps_pkg::INDEX_W){1'b0}},
                 sym, idx};
    do @(posedge clk); while (!s_tready);
    beat_cnt++;
    track_beat(f, idx, sym, lst, got, pred);
    if (got) found_q.insert(found_q.size(), typed < 0 ? pred : (typed != 0));
  endtask

  task automatic write_reg(input logic [kmps_pkg::REG_IDX_W-1:0] ri,
                           input logic [kmps_pkg::LEN_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (ri == kmps_pkg::REG_MAX_MM) cfg_mm = v[kmps_pkg::LIM_W-1:0];
    else cfg_len = v;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_read(input int lo, input int span);
    logic [kmps_pkg::SYM_W-1:0] rd [$];
    logic [kmps_pkg::SYM_W-1:0] win [$];
    int len;
    int lim;
    int m;
    int p;
    bit ok;
    len = cfg_len;
    ok  = (len >= 1 && len <= kmps_pkg::MAX_PROBE);
    lim = ok ? eff_limit(len) : 0;
    repeat ($urandom_range(0, 6))
      rd.insert(rd.size(), kmps_pkg::SYM_W'(lo + $urandom_range(0, span)));
    if (ok && $urandom_range(0, 9) < 7) begin
      for (int i = 0; i < len; i++) win.insert(win.size(), probe_mem[i]);
      case ($urandom_range(0, 3))
        0: m = 0;
        1: m = lim;
        2: m = lim + 1;
        default: m = $urandom_range(0, lim + 2);
      endcase
      if (m > len) m = len;
      repeat (m) begin
        p = $urandom_range(0, len - 1);
        win[p] = win[p] ^ kmps_pkg::SYM_W'($urandom_range(1, 255));
      end
      rd = {rd, win};
    end else begin
      repeat ($urandom_range(1, 48))
        rd.insert(rd.size(), kmps_pkg::SYM_W'(lo + $urandom_range(0, span)));
    end
    repeat ($urandom_range(0, 6))
      rd.insert(rd.size(), kmps_pkg::SYM_W'(lo + $urandom_range(0, span)));
    foreach (rd[i]) begin
      if ($urandom_range(0, 99) < 4) begin
        p = (ok && $urandom_range(0, 1)) ? $urandom_range(0, len - 1) : $urandom_range(0, 511);
        send_beat(kmps_pkg::FUNC_LOAD, kmps_pkg::INDEX_W'(p),
                  kmps_pkg::SYM_W'(lo + $urandom_range(0, span)),
                  1'($urandom_range(0, 1)), NO_TYPED);
      end
      send_beat(kmps_pkg::FUNC_READ, kmps_pkg::INDEX_W'($urandom_range(0, 511)), rd[i],
                (i == rd.size() - 1), NO_TYPED);
    end
  endtask

  task automatic run_phase(input int len, input int k);
    int lo;
    int span;
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(kmps_pkg::REG_MAX_MM, {4'($urandom_range(0, 15)), 6'(k)});
      write_reg(kmps_pkg::REG_PROBE_LEN, kmps_pkg::LEN_W'(len));
    end else begin
      write_reg(kmps_pkg::REG_PROBE_LEN, kmps_pkg::LEN_W'(len));
      write_reg(kmps_pkg::REG_MAX_MM, {4'($urandom_range(0, 15)), 6'(k)});
    end
    burst = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 1)) begin
      lo   = 0;
      span = 255;
    end else begin
      lo   = $urandom_range(0, 252);
      span = 3;
    end
    if (len >= 1 && len <= kmps_pkg::MAX_PROBE) begin
      for (int i = 0; i < len; i++)
        send_beat(kmps_pkg::FUNC_LOAD, kmps_pkg::INDEX_W'(i),
                  kmps_pkg::SYM_W'(lo + $urandom_range(0, span)),
                  ($urandom_range(0, 9) == 0), NO_TYPED);
    end else begin
      repeat (3) send_beat(kmps_pkg::FUNC_LOAD, kmps_pkg::INDEX_W'($urandom_range(0, 511)),
                           kmps_pkg::SYM_W'($urandom), 1'b0, NO_TYPED);
    end
    repeat ($urandom_range(3, 6)) run_read(lo, span);
    burst = 1'b0;
  endtask

  initial begin
    m_tready <= 1'b0;
    @(negedge clk);
    forever begin
      int g;
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        g = HOLD_CYCLES;
      end else begin
        g = pick_gap();
      end
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (found_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat: found=%0b", m_tdata[0]);
      end else begin
        exp_found = found_q.pop_front();
        if (m_tdata[0] !== exp_found) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("found mismatch: expected %0b, got %0b", exp_found, m_tdata[0]);
        end
      end
    end
  end

  initial begin
    int ph;
    int len;
    int k;
    int r;
    int base;
    logic [kmps_pkg::SYM_W-1:0] s;
    clear_read();
    cfg_mm  = 0;
    cfg_len = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_beat(DIR_ROWS[i].func, DIR_ROWS[i].index, DIR_ROWS[i].symbol, DIR_ROWS[i].last,
                DIR_ROWS[i].typed ? int'(DIR_ROWS[i].found) : NO_TYPED);

    // long result back-pressure while single-beat reads keep coming
    settle();
    hold_req = 1'b1;
    wait (hold_req == 1'b0);
    burst    = 1'b1;
    repeat (16) send_beat(kmps_pkg::FUNC_READ, kmps_pkg::INDEX_W'($urandom_range(0, 511)),
                          kmps_pkg::SYM_W'($urandom), 1'b1, NO_TYPED);
    burst = 1'b0;

    base = beat_cnt;
    ph   = 0;
    while (beat_cnt - base < RAND_BEATS) begin
      if (ph == 0) begin
        len = 0;
        k   = 0;
      end else if (ph == 1) begin
        len = 1023;
        k   = 63;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 40);
        else if (r < 95) len = $urandom_range(41, 160);
        else if (r < 98) len = 0;
        else len = $urandom_range(513, 1023);
        if ($urandom_range(0, 9) < 6) k = $urandom_range(0, (len / 8 > 63) ? 63 : len / 8);
        else k = $urandom_range(0, 63);
      end
      run_phase(len, k);
      ph++;
    end

    // full-size probe at the widest limit; flank windows saturate their counts
    settle();
    write_reg(kmps_pkg::REG_PROBE_LEN, kmps_pkg::LEN_W'(kmps_pkg::MAX_PROBE));
    write_reg(kmps_pkg::REG_MAX_MM, 10'd63);
    for (int i = 0; i < kmps_pkg::MAX_PROBE; i++)
      send_beat(kmps_pkg::FUNC_LOAD, kmps_pkg::INDEX_W'(i), kmps_pkg::SYM_W'($urandom),
                1'b0, NO_TYPED);
    repeat (PRE_BEATS) send_beat(kmps_pkg::FUNC_READ,
                                 kmps_pkg::INDEX_W'($urandom_range(0, 511)),
                                 kmps_pkg::SYM_W'($urandom), 1'b0, NO_TYPED);
    for (int i = 0; i < kmps_pkg::MAX_PROBE; i++) begin
      s = probe_mem[i];
      if (i % 8 == 0 && i / 8 < 63) s = s ^ 8'h5A;
      send_beat(kmps_pkg::FUNC_READ, kmps_pkg::INDEX_W'($urandom_range(0, 511)), s,
                (i == kmps_pkg::MAX_PROBE - 1),
                (i == kmps_pkg::MAX_PROBE - 1) ? 1 : NO_TYPED);
    end

    settle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && found_q.size() == 0) begin
      $display("k_mismatch_probe_search_unit_tb: clean");
    end else begin
      $display("k_mismatch_probe_search_unit_tb: errors");
    end
    $finish;
  end

endmodule
